>>> rtl/hall_key_rapid_trigger_top_macros.svh
// ----------------------------------------------------------------------------
// Hall key rapid trigger assertion macros
// Shared macros for the concurrent checks on the top-level ports.
// ----------------------------------------------------------------------------
`ifndef HALL_KEY_RAPID_TRIGGER_TOP_MACROS_SVH
`define HALL_KEY_RAPID_TRIGGER_TOP_MACROS_SVH

// Checked on every clock edge outside reset.
`define HKRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HKRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/hkrt_pkg.sv
// ----------------------------------------------------------------------------
// Hall key rapid trigger package
// Types, codes and constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package hkrt_pkg;

  localparam int ROWS_DEF     = 4;
  localparam int COLS_DEF     = 16;
  localparam int ADC_BITS     = 12;
  localparam int BOUND_W      = ADC_BITS + 1;
  localparam int TABLE_LEN    = 1025;
  localparam int TAB_AW       = 11;
  localparam int TAB_MAX      = TABLE_LEN - 1;
  localparam int NORM_SHIFT   = 10;
  localparam int DIV_STEPS    = 11;
  localparam int NUM_W        = BOUND_W + DIV_STEPS;
  localparam int POS_W        = 16;
  localparam int TRAVEL_W     = 10;
  localparam int SENS_W       = 10;
  localparam int GROW_W       = 12;
  localparam int CFG_W        = 12;

  localparam int TRAVEL_RESET = 350;
  localparam int SENS_RESET   = 20;
  localparam int GROW_RESET   = 100;
  localparam int RELEASE_GAP  = 10;
  localparam int SCALE_ROUND  = 512;
  localparam int CAL_ROUND    = 50;
  localparam int CAL_RECIP    = 5243;
  localparam int CAL_SHIFT    = 19;
  localparam int TRAVEL_ALT   = 320;
  localparam int MULT_ALT     = 12;
  localparam int MULT_STD     = 15;

  localparam logic [1:0] FUNC_SCAN  = 2'd0;
  localparam logic [1:0] FUNC_CAL   = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;
  localparam logic [1:0] FUNC_RSVD  = 2'd3;

  localparam logic [1:0] MODE_FIXED = 2'd0;
  localparam logic [1:0] MODE_POINT = 2'd1;
  localparam logic [1:0] MODE_ZERO  = 2'd2;

  localparam logic [1:0] CFG_TRAVEL = 2'd0;
  localparam logic [1:0] CFG_SENS   = 2'd1;
  localparam logic [1:0] CFG_GROW   = 2'd2;

  typedef struct packed {
    logic capture;
    logic rd_key;
    logic load_w;
    logic zero_res;
    logic bound;
    logic div_step;
    logic tab_rd;
    logic mul;
    logic scale;
    logic decide;
    logic cal_q;
    logic cal_w;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       key_ok;
  } sts_t;

endpackage

>>> rtl/hkrt_ram.sv
// ----------------------------------------------------------------------------
// Hall key rapid trigger RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hkrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/hkrt_ctrl.sv
// ----------------------------------------------------------------------------
// Hall key rapid trigger controller
// Sequences capture, bounds, division, lookup, decision, calibration, output.
// ----------------------------------------------------------------------------
module hkrt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  hkrt_pkg::sts_t sts_i,
  output hkrt_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_BOUND, ST_DIV, ST_TREAD, ST_MUL, ST_SCALE,
    ST_DECIDE, ST_CALQ, ST_CALW, ST_DONE
  } state_e;

  localparam int CNT_W = $clog2(hkrt_pkg::DIV_STEPS);

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             bypass;
  hkrt_pkg::cmd_t   cmd;

  assign bypass = (sts_i.func == hkrt_pkg::FUNC_LOAD) || (sts_i.func == hkrt_pkg::FUNC_RSVD) ||
                  !sts_i.key_ok;

  always_comb begin
    cmd = '0;
    unique case (state_q)
      ST_IDLE: cmd.capture = in_valid_i;
      ST_READ: begin
        cmd.rd_key   = 1'b1;
        cmd.load_w   = (sts_i.func == hkrt_pkg::FUNC_LOAD);
        cmd.zero_res = bypass;
      end
      ST_BOUND:  cmd.bound    = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_TREAD:  cmd.tab_rd   = 1'b1;
      ST_MUL:    cmd.mul      = 1'b1;
      ST_SCALE:  cmd.scale    = 1'b1;
      ST_DECIDE: cmd.decide   = 1'b1;
      ST_CALQ:   cmd.cal_q    = 1'b1;
      ST_CALW:   cmd.cal_w    = 1'b1;
      ST_DONE:   cmd.out_load = !out_valid_q || out_ready_i;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          if (bypass) begin
            state_q <= ST_DONE;
          end else if (sts_i.func == hkrt_pkg::FUNC_CAL) begin
            state_q <= ST_CALQ;
          end else begin
            state_q <= ST_BOUND;
          end
        end
        ST_BOUND: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(hkrt_pkg::DIV_STEPS - 1)) begin
            state_q <= ST_TREAD;
          end
        end
        ST_TREAD:  state_q <= ST_MUL;
        ST_MUL:    state_q <= ST_SCALE;
        ST_SCALE:  state_q <= ST_DECIDE;
        ST_DECIDE: state_q <= ST_DONE;
        ST_CALQ:   state_q <= ST_CALW;
        ST_CALW:   state_q <= ST_DONE;
        ST_DONE: begin
          if (cmd.out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

>>> rtl/hkrt_dp.sv
// ----------------------------------------------------------------------------
// Hall key rapid trigger datapath
// Configuration, key state and bound memories, divider, table and decision.
// ----------------------------------------------------------------------------
module hkrt_dp #(
  parameter int ROWS = hkrt_pkg::ROWS_DEF,
  parameter int COLS = hkrt_pkg::COLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [hkrt_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic [1:0]                  func_i,
  input  logic [1:0]                  key_row_i,
  input  logic [3:0]                  key_col_i,
  input  logic [11:0]                 sample_i,
  input  logic [1:0]                  trigger_mode_i,
  input  logic [9:0]                  act_point_i,
  input  logic [10:0]                 table_index_i,
  input  logic [15:0]                 table_word_i,
  input  hkrt_pkg::cmd_t              cmd_i,
  output hkrt_pkg::sts_t              sts_o,
  output logic                        pressed_o,
  output logic                        changed_o,
  output logic [15:0]                 position_o,
  output logic                        rapid_active_o
);

  localparam int NKEYS = ROWS * COLS;
  localparam int KEY_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int BW    = hkrt_pkg::BOUND_W;
  localparam int AB    = hkrt_pkg::ADC_BITS;
  localparam int PW    = hkrt_pkg::POS_W;
  localparam int KS_W  = PW + 2;
  localparam int NW    = hkrt_pkg::NUM_W;
  localparam int QW    = hkrt_pkg::DIV_STEPS;
  localparam int PRODW = PW + hkrt_pkg::TRAVEL_W;

  logic [hkrt_pkg::TRAVEL_W-1:0] travel_q;
  logic [hkrt_pkg::SENS_W-1:0]   sens_q;
  logic [hkrt_pkg::GROW_W-1:0]   grow_q;

  logic [1:0]       func_q, mode_q;
  logic [KEY_W-1:0] key_q;
  logic             key_ok_q;
  logic [AB-1:0]    s_q;
  logic [9:0]       ap_q;
  logic [10:0]      tidx_q;
  logic [15:0]      tword_q;

  logic [NKEYS-1:0] kv_q;
  logic             kvr_q;
  logic [KS_W-1:0]  key_rd, key_wd;
  logic             key_we;
  logic [2*BW-1:0]  bnd_rd, bnd_wd;
  logic             bnd_we;
  logic [PW-1:0]    tab_rd;
  logic [hkrt_pkg::TAB_AW-1:0] tab_ra;

  logic [BW-1:0]    rem_q, range_q;
  logic [QW-1:0]    nlo_q, quo_q;
  logic             empty_q;
  logic [PRODW-1:0] prod_q;
  logic [PW-1:0]    pos_q;
  logic [6:0]       calq_q;

  logic             pend_pr_q, pend_ch_q, pend_ra_q;
  logic [PW-1:0]    pend_pos_q;
  logic             out_pr_q, out_ch_q, out_ra_q;
  logic [PW-1:0]    out_pos_q;

  // Bound update and divider setup.
  logic [BW-1:0]    hi, lo, s_ext, v1, v, hi_e, rng, diff;
  logic [BW:0]      hi_gm;
  logic             grow, empty;
  logic [NW-1:0]    num;
  // Divider step.
  logic [BW:0]      trial;
  logic             ge;
  // Scale.
  logic [PRODW:0]   sum;
  // Decision.
  logic             st_pr, st_rf, nx_pr, nx_rf;
  logic [PW-1:0]    st_le, nx_le;
  logic             rel_sens, trig_sens, rel_ap, trig_ap;
  // Calibration.
  logic [BW-1:0]    cal_x;
  logic [2*BW-1:0]  cal_prod;
  logic [3:0]       mult;
  logic [10:0]      offset;
  logic [BW-1:0]    hi_c, lo_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      travel_q <= hkrt_pkg::TRAVEL_W'(hkrt_pkg::TRAVEL_RESET);
      sens_q   <= hkrt_pkg::SENS_W'(hkrt_pkg::SENS_RESET);
      grow_q   <= hkrt_pkg::GROW_W'(hkrt_pkg::GROW_RESET);
      kv_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          hkrt_pkg::CFG_TRAVEL: travel_q <= cfg_data_i[hkrt_pkg::TRAVEL_W-1:0];
          hkrt_pkg::CFG_SENS:   sens_q   <= cfg_data_i[hkrt_pkg::SENS_W-1:0];
          hkrt_pkg::CFG_GROW:   grow_q   <= cfg_data_i[hkrt_pkg::GROW_W-1:0];
          default: ;
        endcase
      end
      if (key_we) begin
        kv_q[key_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      mode_q   <= trigger_mode_i;
      key_q    <= KEY_W'(int'(key_row_i) * COLS + int'(key_col_i));
      key_ok_q <= (int'(key_row_i) < ROWS) && (int'(key_col_i) < COLS);
      s_q      <= sample_i[AB-1:0];
      ap_q     <= act_point_i;
      tidx_q   <= table_index_i;
      tword_q  <= table_word_i;
    end
    if (cmd_i.rd_key) begin
      kvr_q <= kv_q[key_q];
    end
    if (cmd_i.bound) begin
      rem_q   <= num[NW-1:QW];
      nlo_q   <= num[QW-1:0];
      range_q <= rng;
      empty_q <= empty;
      quo_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? BW'(trial - {1'b0, range_q}) : trial[BW-1:0];
      nlo_q <= {nlo_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
    if (cmd_i.mul) begin
      prod_q <= PRODW'(tab_rd) * PRODW'(travel_q);
    end
    if (cmd_i.scale) begin
      pos_q <= empty_q ? '0 : sum[PRODW-1:hkrt_pkg::NORM_SHIFT];
    end
    if (cmd_i.cal_q) begin
      calq_q <= cal_prod[hkrt_pkg::CAL_SHIFT +: 7];
    end
    if (cmd_i.zero_res) begin
      pend_pr_q  <= 1'b0;
      pend_ch_q  <= 1'b0;
      pend_ra_q  <= 1'b0;
      pend_pos_q <= '0;
    end else if (cmd_i.decide) begin
      pend_pr_q  <= nx_pr;
      pend_ch_q  <= nx_pr != st_pr;
      pend_ra_q  <= nx_rf;
      pend_pos_q <= pos_q;
    end else if (cmd_i.cal_w) begin
      pend_pr_q  <= st_pr;
      pend_ch_q  <= 1'b0;
      pend_ra_q  <= 1'b0;
      pend_pos_q <= '0;
    end
    if (cmd_i.out_load) begin
      out_pr_q  <= pend_pr_q;
      out_ch_q  <= pend_ch_q;
      out_ra_q  <= pend_ra_q;
      out_pos_q <= pend_pos_q;
    end
  end

  always_comb begin
    hi    = bnd_rd[2*BW-1:BW];
    lo    = bnd_rd[BW-1:0];
    s_ext = BW'(s_q);
    hi_gm = {1'b0, hi} + (BW+1)'(grow_q);
    grow  = (BW+1)'(s_q) > hi_gm;
    v1    = (s_ext < lo) ? lo : s_ext;
    v     = grow ? s_ext : ((v1 > hi) ? hi : v1);
    hi_e  = grow ? s_ext : hi;
    empty = hi_e <= lo;
    rng   = hi_e - lo;
    diff  = v - lo;
    num   = {1'b0, diff, hkrt_pkg::NORM_SHIFT'(0)} + NW'(rng[BW-1:1]);
  end

  assign trial = {rem_q, nlo_q[QW-1]};
  assign ge    = trial >= {1'b0, range_q};
  assign tab_ra = (quo_q > QW'(hkrt_pkg::TAB_MAX)) ? QW'(hkrt_pkg::TAB_MAX) : quo_q;
  assign sum   = {1'b0, prod_q} + (PRODW+1)'(hkrt_pkg::SCALE_ROUND);

  always_comb begin
    {st_pr, st_rf, st_le} = kvr_q ? key_rd : '0;
    rel_sens  = ({1'b0, pos_q} + (PW+1)'(sens_q)) < {1'b0, st_le};
    trig_sens = {1'b0, pos_q} > ({1'b0, st_le} + (PW+1)'(sens_q));
    rel_ap    = ({1'b0, pos_q} + (PW+1)'(hkrt_pkg::RELEASE_GAP)) <= (PW+1)'(ap_q);
    trig_ap   = pos_q > PW'(ap_q);
    nx_pr = st_pr;
    nx_rf = st_rf;
    nx_le = st_le;
    if (mode_q != hkrt_pkg::MODE_FIXED) begin
      if (st_rf) begin
        if (st_pr) begin
          if (pos_q > st_le) begin
            nx_le = pos_q;
          end else if (rel_sens) begin
            nx_pr = 1'b0;
            nx_le = pos_q;
          end
        end else begin
          if (pos_q < st_le) begin
            nx_le = pos_q;
          end else if (trig_sens) begin
            nx_pr = 1'b1;
            nx_le = pos_q;
          end
        end
        if ((mode_q == hkrt_pkg::MODE_POINT && rel_ap) ||
            (mode_q == hkrt_pkg::MODE_ZERO && pos_q == '0)) begin
          nx_pr = 1'b0;
          nx_le = pos_q;
          nx_rf = 1'b0;
        end
      end else if (trig_ap) begin
        nx_pr = 1'b1;
        nx_le = pos_q;
        nx_rf = 1'b1;
      end
    end else begin
      if (st_pr) begin
        if (rel_ap) begin
          nx_pr = 1'b0;
        end
      end else if (trig_ap) begin
        nx_pr = 1'b1;
      end
    end
  end

  always_comb begin
    cal_x    = BW'(s_q) + BW'(hkrt_pkg::CAL_ROUND);
    cal_prod = (2*BW)'(cal_x) * (2*BW)'(hkrt_pkg::CAL_RECIP);
    mult     = (travel_q == hkrt_pkg::TRAVEL_W'(hkrt_pkg::TRAVEL_ALT)) ?
               4'(hkrt_pkg::MULT_ALT) : 4'(hkrt_pkg::MULT_STD);
    offset   = 11'(calq_q) * 11'(mult);
    hi_c     = BW'(s_q) + BW'(offset);
    lo_c     = BW'(s_q) + BW'(1);
  end

  assign key_we = cmd_i.decide || cmd_i.cal_w;
  assign key_wd = cmd_i.decide ? {nx_pr, nx_rf, nx_le} : {st_pr, 1'b0, PW'(0)};
  assign bnd_we = (cmd_i.bound && grow) || cmd_i.cal_w;
  assign bnd_wd = cmd_i.cal_w ? {hi_c, lo_c} : {s_ext, lo};

  hkrt_ram #(.WIDTH(KS_W), .DEPTH(NKEYS), .AW(KEY_W)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_q),
    .wdata_i (key_wd),
    .re_i    (cmd_i.rd_key),
    .raddr_i (key_q),
    .rdata_o (key_rd)
  );

  hkrt_ram #(.WIDTH(2*BW), .DEPTH(NKEYS), .AW(KEY_W)) u_bnd_ram (
    .clk_i   (clk_i),
    .we_i    (bnd_we),
    .waddr_i (key_q),
    .wdata_i (bnd_wd),
    .re_i    (cmd_i.rd_key),
    .raddr_i (key_q),
    .rdata_o (bnd_rd)
  );

  hkrt_ram #(.WIDTH(PW), .DEPTH(hkrt_pkg::TABLE_LEN), .AW(hkrt_pkg::TAB_AW)) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_w && (tidx_q <= hkrt_pkg::TAB_AW'(hkrt_pkg::TAB_MAX))),
    .waddr_i (tidx_q),
    .wdata_i (tword_q),
    .re_i    (cmd_i.tab_rd),
    .raddr_i (tab_ra),
    .rdata_o (tab_rd)
  );

  assign sts_o.func   = func_q;
  assign sts_o.key_ok = key_ok_q;

  assign pressed_o      = out_pr_q;
  assign changed_o      = out_ch_q;
  assign position_o     = out_pos_q;
  assign rapid_active_o = out_ra_q;

endmodule

>>> rtl/hall_key_rapid_trigger_top.sv
// ----------------------------------------------------------------------------
// Hall key rapid trigger top level
// Analog hall-sensor key scanner with fixed actuation and rapid trigger.
// ----------------------------------------------------------------------------
// One input transfer carries one key item: scan a sample, calibrate a key or
// load a position table word. Every item gives exactly one result transfer.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must write them only while the block is idle, as the
// block itself does not enforce it.
// A scan passes bound update, the 11-step restoring divider that normalizes
// the sample, table read, scaling multiply and the trigger decision. A
// calibration sets the key's bounds from the sample; a table load or an
// ignored item goes straight to the result. One item is worked on at a time,
// and the next input transfer can follow in the cycle after the result is
// loaded. A stalled receiver blocks input only after one result waits in the
// output register and the next one is finished behind it.
// Reset restores the register defaults and clears all key pressed, rapid and
// extreme state; bounds and the position table hold nothing until written.
module hall_key_rapid_trigger_top #(
  parameter int ROWS = hkrt_pkg::ROWS_DEF,
  parameter int COLS = hkrt_pkg::COLS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [hkrt_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 func_i,
  input  logic [1:0]                 key_row_i,
  input  logic [3:0]                 key_col_i,
  input  logic [11:0]                sample_i,
  input  logic [1:0]                 trigger_mode_i,
  input  logic [9:0]                 act_point_i,
  input  logic [10:0]                table_index_i,
  input  logic [15:0]                table_word_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       pressed_o,
  output logic                       changed_o,
  output logic [15:0]                position_o,
  output logic                       rapid_active_o
);

  hkrt_pkg::cmd_t cmd;
  hkrt_pkg::sts_t sts;

  hkrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hkrt_dp #(.ROWS(ROWS), .COLS(COLS)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .func_i            (func_i),
    .key_row_i         (key_row_i),
    .key_col_i         (key_col_i),
    .sample_i          (sample_i),
    .trigger_mode_i    (trigger_mode_i),
    .act_point_i       (act_point_i),
    .table_index_i     (table_index_i),
    .table_word_i      (table_word_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .pressed_o         (pressed_o),
    .changed_o         (changed_o),
    .position_o        (position_o),
    .rapid_active_o    (rapid_active_o)
  );

endmodule

>>> rtl/hkrt_checker.sv
// ----------------------------------------------------------------------------
// Hall key rapid trigger checker
// Port-level checks on the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "hall_key_rapid_trigger_top_macros.svh"

module hkrt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i
);

  `HKRT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")
  `HKRT_ASSERT(a_busy_after_in, in_valid_i && in_ready_o |=> !in_ready_o, "ready while busy")
  `HKRT_ASSERT(a_result_on_free, $rose(in_ready_o) |-> out_valid_o, "item finished without result")
  `HKRT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o || rst_ni, "result during reset")

endmodule

bind hall_key_rapid_trigger_top hkrt_checker u_hkrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);
